FILE: hdl/tkst_pkg.sv
// ----------------------------------------------------------------------------
// tkst_pkg: shared types and constants of the top-k score tracker.
// Holds the store geometry, the controller/datapath link and the pair order.
// ----------------------------------------------------------------------------
package tkst_pkg;

  localparam int unsigned CAPACITY = 8;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned KEEP_W   = 4;
  localparam int unsigned SCORE_W  = 32;
  localparam int unsigned INDEX_W  = 32;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(5);

  localparam logic FUNC_OFFER = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic latch;
    logic append;
    logic scan_start;
    logic drain_start;
    logic min_step;
    logic max_step;
    logic replace;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_func;
    logic cnt_zero;
    logic room;
    logic scan_end;
    logic emit_last;
    logic out_free;
  } dp_status_t;

  // True when pair a orders strictly below pair b: signed score first, then index.
  function automatic logic pair_less(input logic [SCORE_W-1:0] sa,
                                     input logic [INDEX_W-1:0] ia,
                                     input logic [SCORE_W-1:0] sb,
                                     input logic [INDEX_W-1:0] ib);
    logic res;
    if (sa != sb) begin
      res = $signed(sa) < $signed(sb);
    end else begin
      res = ia < ib;
    end
    return res;
  endfunction

endpackage

FILE: hdl/tkst_ctrl.sv
// ----------------------------------------------------------------------------
// tkst_ctrl: sequencer of the top-k score tracker.
// Steps the datapath through appends, minimum scans, replacements and drains.
// ----------------------------------------------------------------------------
module tkst_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  input  tkst_pkg::dp_status_t   status_i,
  output tkst_pkg::ctrl_cmd_t    cmd_o
);
  import tkst_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MIN  = 3'd1;
  localparam logic [2:0] S_REPL = 3'd2;
  localparam logic [2:0] S_MAX  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_q, state_d;
  ctrl_cmd_t  cmd;

  always_comb begin
    state_d   = state_q;
    cmd       = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd.latch = 1'b1;
          if (status_i.in_func == FUNC_OFFER) begin
            if (status_i.room) begin
              cmd.append = 1'b1;
            end else if (!status_i.cnt_zero) begin
              cmd.scan_start = 1'b1;
              state_d        = S_MIN;
            end
          end else if (!status_i.cnt_zero) begin
            cmd.scan_start  = 1'b1;
            cmd.drain_start = 1'b1;
            state_d         = S_MAX;
          end
        end
      end
      S_MIN: begin
        cmd.min_step = 1'b1;
        if (status_i.scan_end) begin
          state_d = S_REPL;
        end
      end
      S_REPL: begin
        cmd.replace = 1'b1;
        state_d     = S_IDLE;
      end
      S_MAX: begin
        cmd.max_step = 1'b1;
        if (status_i.scan_end) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd.emit = 1'b1;
          if (status_i.emit_last) begin
            state_d = S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            state_d        = S_MAX;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/tkst_datapath.sv
// ----------------------------------------------------------------------------
// tkst_datapath: pair store, scan unit and output register of the tracker.
// One stored pair is compared per cycle against the running best candidate.
// ----------------------------------------------------------------------------
module tkst_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tkst_pkg::KEEP_W-1:0]   cfg_wdata_i,
  input  logic                          in_func_i,
  input  logic [tkst_pkg::SCORE_W-1:0]  in_score_i,
  input  logic [tkst_pkg::INDEX_W-1:0]  in_index_i,
  input  tkst_pkg::ctrl_cmd_t           cmd_i,
  output tkst_pkg::dp_status_t          status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tkst_pkg::SCORE_W-1:0]  out_score_o,
  output logic [tkst_pkg::INDEX_W-1:0]  out_index_o,
  output logic                          out_last_o
);
  import tkst_pkg::*;

  logic [SCORE_W-1:0]  score_q [CAPACITY];
  logic [INDEX_W-1:0]  index_q [CAPACITY];
  logic [CNT_W-1:0]    count_q;
  logic [KEEP_W-1:0]   keep_q;
  logic [IDX_W-1:0]    ptr_q;
  logic [CAPACITY-1:0] done_q;
  logic [CNT_W-1:0]    emit_cnt_q;
  logic                have_best_q;
  logic [IDX_W-1:0]    best_slot_q;
  logic [SCORE_W-1:0]  best_score_q;
  logic [INDEX_W-1:0]  best_index_q;
  logic [SCORE_W-1:0]  hold_score_q;
  logic [INDEX_W-1:0]  hold_index_q;
  logic                out_valid_q;
  logic [SCORE_W-1:0]  out_score_q;
  logic [INDEX_W-1:0]  out_index_q;
  logic                out_last_q;

  logic [CNT_W-1:0]    limit;
  logic [CNT_W-1:0]    count_m1;
  logic [SCORE_W-1:0]  rd_score;
  logic [INDEX_W-1:0]  rd_index;
  logic                take_min;
  logic                take_max;
  logic                out_free;
  logic                emit_last;

  always_comb begin
    if ({{(32-KEEP_W){1'b0}}, keep_q} > 32'(CAPACITY)) begin
      limit = CNT_W'(CAPACITY);
    end else begin
      limit = CNT_W'(keep_q);
    end
  end

  assign count_m1  = count_q - CNT_W'(1);
  assign rd_score  = score_q[ptr_q];
  assign rd_index  = index_q[ptr_q];
  assign take_min  = !have_best_q
                     || pair_less(rd_score, rd_index, best_score_q, best_index_q);
  assign take_max  = !done_q[ptr_q] && (!have_best_q
                     || pair_less(best_score_q, best_index_q, rd_score, rd_index));
  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_last = (emit_cnt_q == count_m1);

  assign status_o.in_func   = in_func_i;
  assign status_o.cnt_zero  = (count_q == '0);
  assign status_o.room      = (count_q < limit);
  assign status_o.scan_end  = ({{(CNT_W-IDX_W){1'b0}}, ptr_q} == count_m1);
  assign status_o.emit_last = emit_last;
  assign status_o.out_free  = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      hold_score_q <= in_score_i;
      hold_index_q <= in_index_i;
    end
    if (cmd_i.append) begin
      score_q[count_q[IDX_W-1:0]] <= in_score_i;
      index_q[count_q[IDX_W-1:0]] <= in_index_i;
    end
    if (cmd_i.replace && ($signed(hold_score_q) > $signed(best_score_q))) begin
      score_q[best_slot_q] <= hold_score_q;
      index_q[best_slot_q] <= hold_index_q;
    end
    if ((cmd_i.min_step && take_min) || (cmd_i.max_step && take_max)) begin
      best_slot_q  <= ptr_q;
      best_score_q <= rd_score;
      best_index_q <= rd_index;
    end
    if (cmd_i.emit) begin
      out_score_q <= best_score_q;
      out_index_q <= best_index_q;
      out_last_q  <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      keep_q      <= KEEP_RESET;
      ptr_q       <= '0;
      done_q      <= '0;
      emit_cnt_q  <= '0;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        keep_q <= cfg_wdata_i;
      end
      if (cmd_i.append) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.scan_start) begin
        ptr_q       <= '0;
        have_best_q <= 1'b0;
      end else if (cmd_i.min_step || cmd_i.max_step) begin
        ptr_q <= ptr_q + IDX_W'(1);
        if ((cmd_i.min_step && take_min) || (cmd_i.max_step && take_max)) begin
          have_best_q <= 1'b1;
        end
      end
      if (cmd_i.drain_start) begin
        done_q     <= '0;
        emit_cnt_q <= '0;
      end else if (cmd_i.emit) begin
        done_q[best_slot_q] <= 1'b1;
        emit_cnt_q          <= emit_cnt_q + CNT_W'(1);
        if (emit_last) begin
          count_q <= '0;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_score_o = out_score_q;
  assign out_index_o = out_index_q;
  assign out_last_o  = out_last_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {{(32-CNT_W){1'b0}}, count_q} <= 32'(CAPACITY))
    else $error("kept count above capacity");

  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("output register overwritten while held");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && emit_last) |=> (count_q == '0))
    else $error("store not emptied after final pair");

  a_append_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> (count_q < limit))
    else $error("append beyond limit");

endmodule

FILE: hdl/top_k_score_tracker_top.sv
// ----------------------------------------------------------------------------
// top_k_score_tracker_top: keeps the best pairs of a scored stream.
// Offers insert or replace the minimum; a drain emits pairs best first.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         request: tuser = func, tdata = score, item_index
// m_axis    out        result: tdata = out_score, out_index, tlast = last
// cfg       in         keep_count write, no read-back
//
// An offer that fits the store is appended at once; a full store first scans for the minimum, then replaces it.
// A drain of n pairs scans the stored pairs once for each pair it emits, one stored pair read per cycle.
// Reset clears the kept count, scan and output state and restores the keep limit; the store needs no clearing pass.
// The output register lets a new request enter while a result is held.
// A held result stalls only the next drain emit, not offers.
// ----------------------------------------------------------------------------
module top_k_score_tracker_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tkst_pkg::KEEP_W-1:0]   cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // score [31:0], item_index [63:32]
  input  logic [63:0]                   s_axis_tdata_i,
  // func [0]
  input  logic [0:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // out_score [31:0], out_index [63:32]
  output logic [63:0]                   m_axis_tdata_o,
  output logic                          m_axis_tlast_o
);
  import tkst_pkg::*;

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic [SCORE_W-1:0] out_score;
  logic [INDEX_W-1:0] out_index;

  tkst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  tkst_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_func_i   (s_axis_tuser_i[0]),
    .in_score_i  (s_axis_tdata_i[31:0]),
    .in_index_i  (s_axis_tdata_i[63:32]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_score_o (out_score),
    .out_index_o (out_index),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {out_index, out_score};

endmodule

FILE: tb/tb_top_k_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top_k_checker: ranking predictor and result checker for the top-k tracker.
// Watches the configuration, request and result channels. It keeps its own
// copy of the best pairs and of the keep limit, and on every accepted drain it
// queues the pairs best first. Each accepted result is compared with the
// oldest queued pair, field by field.
// ----------------------------------------------------------------------------
module tb_top_k_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tkst_pkg::KEEP_W-1:0] cfg_wdata_i,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [63:0]                 s_tdata_i,
  input  logic [0:0]                  s_tuser_i,
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [63:0]                 m_tdata_i,
  input  logic                        m_tlast_i,
  output int unsigned                 errors_o,
  output int unsigned                 pending_o,
  output int unsigned                 results_o
);

  import tkst_pkg::*;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [INDEX_W-1:0] ident;
    logic               last;
  } ranked_pair_t;

  logic [SCORE_W-1:0] kept_score [CAPACITY];
  logic [INDEX_W-1:0] kept_ident [CAPACITY];
  int unsigned        kept_n;
  logic [KEEP_W-1:0]  keep_lim;
  ranked_pair_t       ranked_q [$];

  // Biasing the sign bit turns the signed score order into an unsigned one.
  function automatic bit ranks_below(input logic [SCORE_W-1:0] sa,
                                     input logic [INDEX_W-1:0] ia,
                                     input logic [SCORE_W-1:0] sb,
                                     input logic [INDEX_W-1:0] ib);
    logic [SCORE_W-1:0] ka;
    logic [SCORE_W-1:0] kb;
    ka = sa ^ {1'b1, {(SCORE_W-1){1'b0}}};
    kb = sb ^ {1'b1, {(SCORE_W-1){1'b0}}};
    if (ka != kb) begin
      return ka < kb;
    end
    return ia < ib;
  endfunction

  task automatic offer_pair(input logic [SCORE_W-1:0] s, input logic [INDEX_W-1:0] id);
    int unsigned room_lim;
    int unsigned m;
    room_lim = (keep_lim > CAPACITY) ? CAPACITY : keep_lim;
    if (kept_n < room_lim) begin
      kept_score[kept_n] = s;
      kept_ident[kept_n] = id;
      kept_n++;
    end else if (kept_n > 0) begin
      m = 0;
      for (int unsigned i = 1; i < kept_n; i++) begin
        if (ranks_below(kept_score[i], kept_ident[i], kept_score[m], kept_ident[m])) begin
          m = i;
        end
      end
      if ($signed(s) > $signed(kept_score[m])) begin
        kept_score[m] = s;
        kept_ident[m] = id;
      end
    end
  endtask

  task automatic drain_store();
    int unsigned  b;
    logic [SCORE_W-1:0] ts;
    logic [INDEX_W-1:0] ti;
    ranked_pair_t rp;
    for (int unsigned i = 0; i < kept_n; i++) begin
      b = i;
      for (int unsigned j = i + 1; j < kept_n; j++) begin
        if (ranks_below(kept_score[b], kept_ident[b], kept_score[j], kept_ident[j])) begin
          b = j;
        end
      end
      ts = kept_score[i];
      ti = kept_ident[i];
      kept_score[i] = kept_score[b];
      kept_ident[i] = kept_ident[b];
      kept_score[b] = ts;
      kept_ident[b] = ti;
      rp.score = kept_score[i];
      rp.ident = kept_ident[i];
      rp.last  = (i + 1 == kept_n);
      ranked_q = {ranked_q, rp};
    end
    kept_n = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ranked_pair_t want;
    int unsigned  bad;
    if (!rst_ni) begin
      kept_n = 0;
      keep_lim = KEEP_RESET;
      ranked_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
      results_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        results_o <= results_o + 1;
        if (ranked_q.size() == 0) begin
          $display("%0t: unexpected pair: expected none, got score %h index %h last %b",
                   $time, m_tdata_i[31:0], m_tdata_i[63:32], m_tlast_i);
          errors_o <= errors_o + 1;
        end else begin
          want = ranked_q.pop_front();
          bad = 0;
          if (m_tdata_i[31:0] !== want.score) begin
            $display("%0t: out_score expected %h, got %h", $time, want.score, m_tdata_i[31:0]);
            bad++;
          end
          if (m_tdata_i[63:32] !== want.ident) begin
            $display("%0t: out_index expected %h, got %h", $time, want.ident, m_tdata_i[63:32]);
            bad++;
          end
          if (m_tlast_i !== want.last) begin
            $display("%0t: last expected %b, got %b", $time, want.last, m_tlast_i);
            bad++;
          end
          errors_o <= errors_o + bad;
        end
      end
      if (cfg_we_i) begin
        keep_lim = cfg_wdata_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i[0] == FUNC_DRAIN) begin
          drain_store();
        end else begin
          offer_pair(s_tdata_i[31:0], s_tdata_i[63:32]);
        end
      end
      pending_o <= ranked_q.size();
    end
  end

endmodule

FILE: tb/tb_top_k_score_tracker_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top_k_score_tracker_top: stimulus and verdict for the top-k tracker.
// Directed offers and drains cover extreme scores, ties and the odd keep
// limits, then random phases of offers closed by drains run under several
// keep limits with random stalls on both channels. A checker module does
// the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top_k_score_tracker_top;

  import tkst_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_CYC   = 20;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 30;
  localparam logic [31:0] SCORE_MIN    = 32'h8000_0000;
  localparam logic [31:0] SCORE_MAX    = 32'h7FFF_FFFF;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic [KEEP_W-1:0] cfg_wdata_i     = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [63:0]       s_axis_tdata_i  = '0;
  logic [0:0]        s_axis_tuser_i  = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b1;
  logic [63:0]       m_axis_tdata_o;
  logic              m_axis_tlast_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned results;
  int unsigned cycle_cnt   = 0;
  int unsigned requests    = 0;
  int unsigned drains      = 0;
  int unsigned keep_writes = 0;
  bit          calm        = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  top_k_score_tracker_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  tb_top_k_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_i  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .m_tvalid_i  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_i   (m_axis_tdata_o),
    .m_tlast_i   (m_axis_tlast_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("top_k_score_tracker_top: mismatch");
      $finish;
    end
  end

  // The receiver stalls in random bursts until the calm part of the run.
  always begin : rx_pacing
    int unsigned n;
    n = $urandom_range(1, 10);
    if (!calm && $urandom_range(0, 2) == 0) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
    repeat (n) @(posedge clk_i);
  end

  task automatic send(input logic fn, input logic [31:0] score, input logic [31:0] ident);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid_i   <= 1'b1;
    s_axis_tuser_i[0] <= fn;
    s_axis_tdata_i    <= {ident, score};
    do @(posedge clk_i); while (!s_axis_tready_o);
    requests++;
    if (fn == FUNC_DRAIN) begin
      drains++;
    end
  endtask

  task automatic offer(input logic [31:0] score, input logic [31:0] ident);
    send(FUNC_OFFER, score, ident);
  endtask

  task automatic drain();
    send(FUNC_DRAIN, $urandom, $urandom);
  endtask

  // Offers leave no result behind, so a settling wait lets the block finish one.
  task automatic set_keep(input logic [KEEP_W-1:0] lim);
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    keep_writes++;
  endtask

  function automatic logic [31:0] pick_score();
    case ($urandom_range(0, 5))
      0:       return {16'($signed($urandom_range(0, 8)) - 4), 16'h0000};
      1:       return SCORE_MIN;
      2:       return SCORE_MAX;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_ident();
    if ($urandom_range(0, 1) == 0) begin
      return $urandom_range(0, 7);
    end
    return $urandom;
  endfunction

  initial begin : stimulus
    logic [KEEP_W-1:0] phase_keep [PHASES];
    phase_keep = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'($urandom_range(1, 8)),
                   4'd8, 4'($urandom_range(0, 15))};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limit of five: empty drain, extremes, ties and replacement rules.
    drain();
    offer(SCORE_MIN, 32'h0000_0000);
    offer(SCORE_MAX, 32'hFFFF_FFFF);
    offer(32'h0005_0000, 32'd7);
    offer(32'h0005_0000, 32'd3);
    offer(32'hFFFF_FFFF, 32'd1);
    offer(SCORE_MIN, 32'd5);
    offer(32'h0005_0000, 32'd9);
    drain();

    // A limit above capacity, then one lowered below the kept number.
    set_keep(4'd15);
    offer(32'h8000_0001, 32'hA5A5_A5A5);
    offer(32'h7FFF_FFFE, 32'd2);
    offer(32'h0001_8000, 32'h5A5A_5A5A);
    set_keep(4'd1);
    offer(32'h0001_8000, 32'd6);

    // A zero limit still replaces in a non-empty store and ignores an empty one.
    set_keep(4'd0);
    offer(SCORE_MAX, 32'd4);
    drain();
    offer(SCORE_MAX, 32'd8);
    drain();

    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p >= PHASES - 2) begin
        calm = 1'b1;
      end
      set_keep(phase_keep[p]);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2 && p % 2 == 1) begin
          set_keep(4'($urandom_range(0, 15)));
        end
        if (k == PHASE_ITEMS - 1 || $urandom_range(0, 7) == 0) begin
          drain();
        end else begin
          offer(pick_score(), pick_ident());
        end
      end
    end

    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d requests, %0d of them drains, under %0d keep_count writes.",
             requests, drains, keep_writes);
    $display("Checked %0d ranked pairs from the result channel.", results);
    if (errors == 0 && pending == 0) begin
      $display("top_k_score_tracker_top: match");
    end else begin
      $display("top_k_score_tracker_top: mismatch");
    end
    $finish;
  end

endmodule
